@@ rtl/latest_value_slot_table_defines.svh @@
// Assertion macros shared by the slot table RTL.
`ifndef LATEST_VALUE_SLOT_TABLE_DEFINES_SVH
`define LATEST_VALUE_SLOT_TABLE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define LVST_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define LVST_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/lvst_pkg.sv @@
// Types, constants and codes for the latest-value slot table.
package lvst_pkg;

  localparam int SLOTS       = 6;
  localparam int PAYLOAD_MAX = 320;
  localparam int SLOT_W      = $clog2(SLOTS);

  localparam int KEY_W  = 32;
  localparam int REF_W  = 32;
  localparam int LEN_W  = 9;
  localparam int VER_W  = 32;
  localparam int STMP_W = 32;
  localparam int IDX_W  = 3;

  localparam logic [1:0] KIND_PUBLISH = 2'd0;
  localparam logic [1:0] KIND_PICK    = 2'd1;
  localparam logic [1:0] KIND_CONFIRM = 2'd2;

  localparam logic [2:0] ST_STORED   = 3'd0;
  localparam logic [2:0] ST_REJECTED = 3'd1;
  localparam logic [2:0] ST_PICKED   = 3'd2;
  localparam logic [2:0] ST_NONE     = 3'd3;
  localparam logic [2:0] ST_CLEARED  = 3'd4;
  localparam logic [2:0] ST_STALE    = 3'd5;

  typedef struct packed {
    logic [1:0]       kind;
    logic [KEY_W-1:0] key;
    logic [REF_W-1:0] payload_ref;
    logic [LEN_W-1:0] payload_len;
    logic [IDX_W-1:0] confirm_slot;
    logic [VER_W-1:0] confirm_version;
  } in_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [IDX_W-1:0] slot_index;
    logic [KEY_W-1:0] out_key;
    logic [REF_W-1:0] out_payload_ref;
    logic [LEN_W-1:0] out_payload_len;
    logic [VER_W-1:0] out_ver;
    logic             still_dirty;
  } out_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [REF_W-1:0] payload_ref;
    logic [LEN_W-1:0] payload_len;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Next slot index in round-robin order.
  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
    logic [SLOT_W-1:0] r;
    if (s == SLOT_W'(SLOTS - 1)) begin
      r = '0;
    end else begin
      r = s + SLOT_W'(1);
    end
    return r;
  endfunction

endpackage

@@ rtl/lvst_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module lvst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/latest_value_slot_table.sv @@
// Latest-value slot table: top level with the slot walk sequencer.
// Publish: walks slots from 0 until a key match (at most SLOTS), then writes the slot.
// Pick: walks slots from the round-robin pointer until a dirty one (at most SLOTS).
// Confirm: one slot. Bad kind or rejected length: no walk. One slot is visited per cycle.
// The result strobe lasts one cycle and cannot be held off; the next item may start during it.
// Synchronous reset empties the table and zeroes the stamp counter and pointer.
`include "latest_value_slot_table_defines.svh"

module latest_value_slot_table (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  lvst_pkg::in_t item,
  output logic          done,
  output lvst_pkg::out_t result
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_WRITE = 3'd2;
  localparam logic [2:0] S_PICK  = 3'd3;
  localparam logic [2:0] S_CONF  = 3'd4;

  localparam int SW = lvst_pkg::SLOT_W;

  logic [2:0] state, state_next;

  logic [lvst_pkg::SLOTS-1:0] used, used_next;
  logic [lvst_pkg::SLOTS-1:0] dirty, dirty_next;
  logic [lvst_pkg::VER_W-1:0] version [lvst_pkg::SLOTS];
  logic [lvst_pkg::VER_W-1:0] version_next [lvst_pkg::SLOTS];
  logic [lvst_pkg::STMP_W-1:0] stamp [lvst_pkg::SLOTS];
  logic [lvst_pkg::STMP_W-1:0] stamp_next [lvst_pkg::SLOTS];
  logic [lvst_pkg::STMP_W-1:0] stamp_counter, stamp_counter_next;
  logic [SW-1:0] rr, rr_next;
  logic done_next;
  lvst_pkg::out_t result_next;

  // Working registers of the walk; no reset needed.
  lvst_pkg::in_t cmd, cmd_next;
  logic [SW-1:0] idx, idx_next;
  logic [SW-1:0] cnt, cnt_next;
  logic have_target, have_target_next;
  logic [SW-1:0] target, target_next;
  logic [lvst_pkg::STMP_W-1:0] oldest, oldest_next;
  logic [SW-1:0] evict_idx, evict_idx_next;

  // Slot contents memory.
  logic ram_we;
  logic [SW-1:0] ram_waddr, ram_raddr;
  lvst_pkg::entry_t ram_wdata, ram_rdata;

  lvst_ram #(
    .WIDTH(lvst_pkg::ENTRY_W),
    .DEPTH(lvst_pkg::SLOTS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Shared slot port: one version and one stamp read a cycle.
  logic [SW-1:0] wr_slot, port_slot;
  logic [lvst_pkg::VER_W-1:0] port_version;
  logic [lvst_pkg::STMP_W-1:0] port_stamp;
  logic key_eq, stamp_lt, ver_eq, len_ok, conf_in_range;

  // Views of the shown result used by the checks below.
  logic [lvst_pkg::SLOTS-1:0] shown_bit;
  logic shown_picked, shown_stored;

  assign busy = (state != S_IDLE);
  assign wr_slot = have_target ? target : evict_idx;
  assign port_slot = (state == S_WRITE) ? wr_slot : idx;
  assign port_version = version[port_slot];
  assign port_stamp = stamp[port_slot];

  // Compare unit shared by the walk states.
  assign key_eq   = (ram_rdata.key == cmd.key);
  assign stamp_lt = (port_stamp < oldest);
  assign ver_eq   = (port_version == cmd.confirm_version);
  assign len_ok   = (item.payload_len != '0) &&
                    (item.payload_len < lvst_pkg::LEN_W'(lvst_pkg::PAYLOAD_MAX));
  assign conf_in_range = (int'(cmd.confirm_slot) < lvst_pkg::SLOTS);

  always_comb begin
    state_next         = state;
    used_next          = used;
    dirty_next         = dirty;
    version_next       = version;
    stamp_next         = stamp;
    stamp_counter_next = stamp_counter;
    rr_next            = rr;
    done_next          = 1'b0;
    result_next        = '0;
    cmd_next           = cmd;
    idx_next           = idx;
    cnt_next           = cnt;
    have_target_next   = have_target;
    target_next        = target;
    oldest_next        = oldest;
    evict_idx_next     = evict_idx;
    ram_we             = 1'b0;
    ram_waddr          = wr_slot;
    ram_wdata.key         = cmd.key;
    ram_wdata.payload_ref = cmd.payload_ref;
    ram_wdata.payload_len = cmd.payload_len;
    ram_raddr          = lvst_pkg::slot_inc(idx);

    unique case (state)
      S_IDLE: begin
        ram_raddr = '0;
        if (start) begin
          cmd_next = item;
          unique case (item.kind)
            lvst_pkg::KIND_PUBLISH: begin
              if (len_ok) begin
                idx_next         = '0;
                have_target_next = 1'b0;
                oldest_next      = '1;
                evict_idx_next   = '0;
                state_next       = S_SCAN;
              end else begin
                done_next               = 1'b1;
                result_next.status      = lvst_pkg::ST_REJECTED;
                result_next.still_dirty = |dirty;
              end
            end
            lvst_pkg::KIND_PICK: begin
              ram_raddr  = rr;
              idx_next   = rr;
              cnt_next   = '0;
              state_next = S_PICK;
            end
            lvst_pkg::KIND_CONFIRM: begin
              if (int'(item.confirm_slot) < lvst_pkg::SLOTS) begin
                idx_next = SW'(item.confirm_slot);
              end else begin
                idx_next = '0;
              end
              state_next = S_CONF;
            end
            default: begin
              done_next               = 1'b1;
              result_next.status      = lvst_pkg::ST_REJECTED;
              result_next.still_dirty = |dirty;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (used[idx] && key_eq) begin
          have_target_next = 1'b1;
          target_next      = idx;
          state_next       = S_WRITE;
        end else begin
          if (used[idx] && stamp_lt) begin
            oldest_next    = port_stamp;
            evict_idx_next = idx;
          end
          if (!used[idx] && !have_target) begin
            have_target_next = 1'b1;
            target_next      = idx;
          end
          if (idx == SW'(lvst_pkg::SLOTS - 1)) begin
            state_next = S_WRITE;
          end else begin
            idx_next = idx + SW'(1);
          end
        end
      end

      S_WRITE: begin
        ram_we                  = 1'b1;
        used_next[wr_slot]      = 1'b1;
        dirty_next[wr_slot]     = 1'b1;
        version_next[wr_slot]   = port_version + lvst_pkg::VER_W'(1);
        stamp_counter_next      = stamp_counter + lvst_pkg::STMP_W'(1);
        stamp_next[wr_slot]     = stamp_counter + lvst_pkg::STMP_W'(1);
        done_next               = 1'b1;
        result_next.status      = lvst_pkg::ST_STORED;
        result_next.slot_index  = lvst_pkg::IDX_W'(wr_slot);
        result_next.still_dirty = 1'b1;
        state_next              = S_IDLE;
      end

      S_PICK: begin
        if (used[idx] && dirty[idx]) begin
          done_next                   = 1'b1;
          result_next.status          = lvst_pkg::ST_PICKED;
          result_next.slot_index      = lvst_pkg::IDX_W'(idx);
          result_next.out_key         = ram_rdata.key;
          result_next.out_payload_ref = ram_rdata.payload_ref;
          result_next.out_payload_len = ram_rdata.payload_len;
          result_next.out_ver         = port_version;
          result_next.still_dirty     = 1'b1;
          rr_next                     = lvst_pkg::slot_inc(idx);
          state_next                  = S_IDLE;
        end else if (cnt == SW'(lvst_pkg::SLOTS - 1)) begin
          done_next               = 1'b1;
          result_next.status      = lvst_pkg::ST_NONE;
          result_next.still_dirty = |dirty;
          state_next              = S_IDLE;
        end else begin
          idx_next = lvst_pkg::slot_inc(idx);
          cnt_next = cnt + SW'(1);
        end
      end

      S_CONF: begin
        done_next              = 1'b1;
        result_next.slot_index = cmd.confirm_slot;
        if (conf_in_range && used[idx] && ver_eq) begin
          dirty_next[idx]         = 1'b0;
          result_next.status      = lvst_pkg::ST_CLEARED;
          result_next.still_dirty = |(dirty & ~(lvst_pkg::SLOTS'(1) << idx));
        end else begin
          result_next.status      = lvst_pkg::ST_STALE;
          result_next.still_dirty = |dirty;
        end
        state_next = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      used          <= '0;
      dirty         <= '0;
      stamp_counter <= '0;
      rr            <= '0;
      done          <= 1'b0;
      for (int i = 0; i < lvst_pkg::SLOTS; i++) begin
        version[i] <= '0;
        stamp[i]   <= '0;
      end
    end else begin
      state         <= state_next;
      used          <= used_next;
      dirty         <= dirty_next;
      stamp_counter <= stamp_counter_next;
      rr            <= rr_next;
      done          <= done_next;
      version       <= version_next;
      stamp         <= stamp_next;
    end
  end

  always_ff @(posedge clk) begin
    result      <= result_next;
    cmd         <= cmd_next;
    idx         <= idx_next;
    cnt         <= cnt_next;
    have_target <= have_target_next;
    target      <= target_next;
    oldest      <= oldest_next;
    evict_idx   <= evict_idx_next;
  end

  assign shown_bit    = lvst_pkg::SLOTS'(1) << result.slot_index;
  assign shown_picked = done && (result.status == lvst_pkg::ST_PICKED);
  assign shown_stored = done && (result.status == lvst_pkg::ST_STORED);

  // A result is only presented once the sequencer is back at rest.
  `LVST_ASSERT_NOW(a_done_idle, done, state == S_IDLE, "result strobe while walking")
  // A slot can only be dirty once it holds a value.
  `LVST_ASSERT_NOW(a_dirty_used, 1'b1, (dirty & ~used) == '0, "dirty slot not in use")
  // A picked slot is still dirty while its result is shown.
  `LVST_ASSERT_NOW(a_pick_dirty, shown_picked, |(dirty & shown_bit), "picked slot not dirty")
  // Round-robin pointer never leaves the table.
  `LVST_ASSERT_NOW(a_rr_range, 1'b1, int'(rr) < lvst_pkg::SLOTS, "pointer out of range")
  // A store reports in the cycle after its write.
  `LVST_ASSERT_NXT(a_store_done, state == S_WRITE, shown_stored, "store did not report")

endmodule

@@ tb/latest_value_slot_table_checker.sv @@
// Checker for the slot table: predicts each result beat from the accepted commands and compares.
module latest_value_slot_table_checker (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic           busy,
  input  lvst_pkg::in_t  item,
  input  logic           done,
  input  lvst_pkg::out_t result,
  output int             mismatches,
  output int             pending
);
  timeunit 1ns;
  timeprecision 1ps;

  bit                          used     [lvst_pkg::SLOTS];
  bit                          dirty    [lvst_pkg::SLOTS];
  logic [lvst_pkg::VER_W-1:0]  version  [lvst_pkg::SLOTS];
  logic [lvst_pkg::STMP_W-1:0] stamp    [lvst_pkg::SLOTS];
  lvst_pkg::entry_t            contents [lvst_pkg::SLOTS];
  logic [lvst_pkg::STMP_W-1:0] stamp_count;
  int                          rr_next;
  lvst_pkg::out_t              expected_q [$];

  initial mismatches = 0;

  function automatic void clear_table();
    for (int i = 0; i < lvst_pkg::SLOTS; i++) begin
      used[i] = 1'b0;
      dirty[i] = 1'b0;
      version[i] = '0;
      stamp[i] = '0;
      contents[i] = '0;
    end
    stamp_count = '0;
    rr_next = 0;
  endfunction

  function automatic bit any_dirty();
    bit hit;
    hit = 1'b0;
    for (int i = 0; i < lvst_pkg::SLOTS; i++) begin
      if (used[i] && dirty[i]) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

  // A used slot with the same key wins, then the lowest free slot, then the
  // oldest stamp with the lowest index on ties.
  function automatic int target_slot(logic [lvst_pkg::KEY_W-1:0] k);
    int                          match_idx;
    int                          open_idx;
    int                          evict_idx;
    int                          pick;
    logic [lvst_pkg::STMP_W-1:0] oldest;
    match_idx = -1;
    open_idx = -1;
    evict_idx = 0;
    oldest = '1;
    for (int i = 0; i < lvst_pkg::SLOTS; i++) begin
      if (used[i]) begin
        if (match_idx < 0 && contents[i].key == k) begin
          match_idx = i;
        end
        if (stamp[i] < oldest) begin
          oldest = stamp[i];
          evict_idx = i;
        end
      end else if (open_idx < 0) begin
        open_idx = i;
      end
    end
    if (match_idx >= 0) begin
      pick = match_idx;
    end else if (open_idx >= 0) begin
      pick = open_idx;
    end else begin
      pick = evict_idx;
    end
    return pick;
  endfunction

  function automatic lvst_pkg::out_t apply_beat(lvst_pkg::in_t it);
    lvst_pkg::out_t r;
    int             s;
    int             c;
    bit             found;
    r = '0;
    case (it.kind)
      lvst_pkg::KIND_PUBLISH: begin
        if (it.payload_len == '0 || it.payload_len >= lvst_pkg::PAYLOAD_MAX) begin
          r.status = lvst_pkg::ST_REJECTED;
        end else begin
          s = target_slot(it.key);
          used[s] = 1'b1;
          dirty[s] = 1'b1;
          version[s] = version[s] + 1'b1;
          stamp_count = stamp_count + 1'b1;
          stamp[s] = stamp_count;
          contents[s].key = it.key;
          contents[s].payload_ref = it.payload_ref;
          contents[s].payload_len = it.payload_len;
          r.status = lvst_pkg::ST_STORED;
          r.slot_index = lvst_pkg::IDX_W'(s);
        end
      end
      lvst_pkg::KIND_PICK: begin
        r.status = lvst_pkg::ST_NONE;
        found = 1'b0;
        for (int n = 0; n < lvst_pkg::SLOTS; n++) begin
          s = (rr_next + n) % lvst_pkg::SLOTS;
          if (!found && used[s] && dirty[s]) begin
            found = 1'b1;
            r.status = lvst_pkg::ST_PICKED;
            r.slot_index = lvst_pkg::IDX_W'(s);
            r.out_key = contents[s].key;
            r.out_payload_ref = contents[s].payload_ref;
            r.out_payload_len = contents[s].payload_len;
            r.out_ver = version[s];
            rr_next = (s + 1) % lvst_pkg::SLOTS;
          end
        end
      end
      lvst_pkg::KIND_CONFIRM: begin
        r.status = lvst_pkg::ST_STALE;
        r.slot_index = it.confirm_slot;
        if (it.confirm_slot < lvst_pkg::SLOTS) begin
          c = int'(it.confirm_slot);
          if (used[c] && version[c] == it.confirm_version) begin
            dirty[c] = 1'b0;
            r.status = lvst_pkg::ST_CLEARED;
          end
        end
      end
      default: begin
        r.status = lvst_pkg::ST_REJECTED;
      end
    endcase
    r.still_dirty = any_dirty();
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] slot table mismatch on %s: got %h, expected %h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic compare_beat(lvst_pkg::out_t got, lvst_pkg::out_t want);
    if (got.status !== want.status) begin
      report_mismatch("status", got.status, want.status);
    end
    if (got.slot_index !== want.slot_index) begin
      report_mismatch("slot_index", got.slot_index, want.slot_index);
    end
    if (got.out_key !== want.out_key) begin
      report_mismatch("out_key", got.out_key, want.out_key);
    end
    if (got.out_payload_ref !== want.out_payload_ref) begin
      report_mismatch("out_payload_ref", got.out_payload_ref, want.out_payload_ref);
    end
    if (got.out_payload_len !== want.out_payload_len) begin
      report_mismatch("out_payload_len", got.out_payload_len, want.out_payload_len);
    end
    if (got.out_ver !== want.out_ver) begin
      report_mismatch("out_ver", got.out_ver, want.out_ver);
    end
    if (got.still_dirty !== want.still_dirty) begin
      report_mismatch("still_dirty", got.still_dirty, want.still_dirty);
    end
  endtask

  // A result beat is checked before the command beat of the same edge is
  // predicted, since the next command may be accepted while a result is out.
  always @(posedge clk) begin
    if (rst) begin
      clear_table();
      expected_q.delete();
    end else begin
      if (done) begin
        if (expected_q.size() == 0) begin
          report_mismatch("result beat with nothing pending", result.status, '0);
        end else begin
          compare_beat(result, expected_q.pop_front());
        end
      end
      if (start && !busy) begin
        expected_q.push_back(apply_beat(item));
      end
    end
    pending <= expected_q.size();
  end

endmodule

@@ tb/latest_value_slot_table_tb.sv @@
// Testbench top for the slot table: clock, reset, command stimulus, watchdog and verdict.
module latest_value_slot_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         ITEMS        = 450;
  localparam int         IDLE_LIMIT   = 2000;
  localparam int         TAIL_CYCLES  = 20;
  localparam int         KEY_POOL     = 8;
  localparam logic [1:0] KIND_UNKNOWN = 2'd3;

  logic           clk;
  logic           rst;
  logic           start;
  logic           busy;
  logic           done;
  lvst_pkg::in_t  item;
  lvst_pkg::out_t result;

  int mismatches;
  int pending;
  int items_sent;
  int results_seen;
  int idle_cycles;
  bit burst;

  logic [lvst_pkg::KEY_W-1:0] key_pool     [KEY_POOL];
  logic [lvst_pkg::VER_W-1:0] seen_version [lvst_pkg::SLOTS];
  logic [lvst_pkg::IDX_W-1:0] last_slot;
  logic [lvst_pkg::VER_W-1:0] last_version;

  latest_value_slot_table dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .done   (done),
    .result (result)
  );

  latest_value_slot_table_checker result_check (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .item       (item),
    .done       (done),
    .result     (result),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("latest_value_slot_table verification failed");
        $finish;
      end
    end
  end

  // Picked versions are kept so that confirms can echo what was really sent.
  always @(posedge clk) begin
    if (rst) begin
      results_seen <= 0;
      last_slot <= '0;
      last_version <= '0;
      for (int i = 0; i < lvst_pkg::SLOTS; i++) begin
        seen_version[i] <= '0;
      end
    end else if (done) begin
      results_seen <= results_seen + 1;
      if (result.status == lvst_pkg::ST_PICKED) begin
        last_slot <= result.slot_index;
        last_version <= result.out_ver;
        if (result.slot_index < lvst_pkg::SLOTS) begin
          seen_version[result.slot_index] <= result.out_ver;
        end
      end
    end
  end

  function automatic lvst_pkg::in_t noise_beat();
    lvst_pkg::in_t it;
    it.kind = 2'($urandom_range(0, 3));
    it.key = $urandom;
    it.payload_ref = $urandom;
    it.payload_len = lvst_pkg::LEN_W'($urandom_range(0, 511));
    it.confirm_slot = lvst_pkg::IDX_W'($urandom_range(0, 7));
    it.confirm_version = $urandom;
    return it;
  endfunction

  function automatic lvst_pkg::in_t publish_beat(logic [lvst_pkg::KEY_W-1:0] k,
                                                 logic [lvst_pkg::LEN_W-1:0] len);
    lvst_pkg::in_t it;
    it = noise_beat();
    it.kind = lvst_pkg::KIND_PUBLISH;
    it.key = k;
    it.payload_len = len;
    return it;
  endfunction

  function automatic lvst_pkg::in_t pick_beat();
    lvst_pkg::in_t it;
    it = noise_beat();
    it.kind = lvst_pkg::KIND_PICK;
    return it;
  endfunction

  function automatic lvst_pkg::in_t confirm_beat(logic [lvst_pkg::IDX_W-1:0] s,
                                                 logic [lvst_pkg::VER_W-1:0] v);
    lvst_pkg::in_t it;
    it = noise_beat();
    it.kind = lvst_pkg::KIND_CONFIRM;
    it.confirm_slot = s;
    it.confirm_version = v;
    return it;
  endfunction

  function automatic logic [lvst_pkg::LEN_W-1:0] good_len();
    logic [lvst_pkg::LEN_W-1:0] len;
    case ($urandom_range(0, 9))
      0: len = lvst_pkg::LEN_W'(1);
      1: len = lvst_pkg::LEN_W'(lvst_pkg::PAYLOAD_MAX - 1);
      default: len = lvst_pkg::LEN_W'($urandom_range(1, lvst_pkg::PAYLOAD_MAX - 1));
    endcase
    return len;
  endfunction

  // Drives one command beat at the falling edge and returns at the rising
  // edge that accepts it. Start stays high across back-to-back beats.
  task automatic push_item(lvst_pkg::in_t it);
    int gap;
    if ($urandom_range(0, 29) == 0) begin
      burst = !burst;
    end
    gap = burst ? 0 : $urandom_range(0, 8);
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    item <= it;
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  task automatic wait_results();
    while (results_seen != items_sent) @(posedge clk);
  endtask

  initial begin : stimulus
    lvst_pkg::in_t              it;
    int                         roll;
    int                         s;
    logic [lvst_pkg::VER_W-1:0] v;
    rst = 1'b1;
    start = 1'b0;
    item = '0;
    items_sent = 0;
    burst = 1'b0;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < KEY_POOL; i++) begin
      key_pool[i] = $urandom;
    end
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Empty table: confirm of an unused slot, pick with nothing dirty, unknown kind.
    push_item(confirm_beat('0, '0));
    push_item(pick_beat());
    it = noise_beat();
    it.kind = KIND_UNKNOWN;
    push_item(it);
    push_item(publish_beat(32'h0000_0001, '0));
    push_item(publish_beat(32'h0000_0002, lvst_pkg::LEN_W'(lvst_pkg::PAYLOAD_MAX)));
    push_item(publish_beat(32'h0000_0003, '1));
    push_item(publish_beat('0, lvst_pkg::LEN_W'(lvst_pkg::PAYLOAD_MAX - 1)));
    push_item(publish_beat('1, lvst_pkg::LEN_W'(1)));
    push_item(publish_beat('0, lvst_pkg::LEN_W'(7)));
    // Four keys fill the table, the fifth evicts the oldest slot.
    for (int i = 0; i < 5; i++) begin
      push_item(publish_beat(32'h0000_0100 + i, lvst_pkg::LEN_W'(8)));
    end
    push_item(pick_beat());
    wait_results();
    push_item(confirm_beat(last_slot, last_version));
    push_item(confirm_beat(last_slot, last_version));
    push_item(confirm_beat(lvst_pkg::IDX_W'(1), '0));
    push_item(confirm_beat(lvst_pkg::IDX_W'(6), '0));
    push_item(confirm_beat(lvst_pkg::IDX_W'(7), '1));

    while (items_sent < ITEMS) begin
      roll = $urandom_range(0, 99);
      if (roll < 40) begin
        repeat ($urandom_range(1, 4)) begin
          push_item(publish_beat(key_pool[$urandom_range(0, KEY_POOL - 1)], good_len()));
        end
        if ($urandom_range(0, 9) == 0) begin
          key_pool[$urandom_range(0, KEY_POOL - 1)] = $urandom;
        end
      end else if (roll < 65) begin
        push_item(pick_beat());
        if ($urandom_range(0, 1) == 1) begin
          wait_results();
          push_item(confirm_beat(last_slot, last_version));
        end
      end else if (roll < 80) begin
        push_item(pick_beat());
      end else if (roll < 92) begin
        s = $urandom_range(0, lvst_pkg::SLOTS - 1);
        v = seen_version[s];
        if ($urandom_range(0, 3) == 0) begin
          v = v + 1'b1;
        end
        push_item(confirm_beat(lvst_pkg::IDX_W'(s), v));
      end else begin
        push_item(noise_beat());
      end
    end

    @(negedge clk);
    start <= 1'b0;
    wait_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("latest_value_slot_table verification clean");
    end else begin
      $display("latest_value_slot_table verification failed");
    end
    $finish;
  end

endmodule
